// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and the sextet-to-character function of the base64 encoder.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package b64e_pkg;

  // Config reset value and queue sizing
  localparam logic [7:0] GROUPS_PER_LINE_RST = 8'd16;
  localparam int         QUEUE_DEPTH         = 2;

  // Character codes
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_LOWER_OFS = 8'd71;   // 'a' minus 26
  localparam logic [7:0] CHAR_DIGIT_OFS = 8'd4;    // 52 minus '0'
  localparam logic [7:0] CHAR_PLUS    = 8'd43;
  localparam logic [7:0] CHAR_SLASH   = 8'd47;
  localparam logic [7:0] CHAR_PAD     = 8'd61;
  localparam logic [7:0] CHAR_FEED    = 8'd10;

  // Character slots within one group
  localparam logic [2:0] SLOT_FIRST  = 3'd0;
  localparam logic [2:0] SLOT_SECOND = 3'd1;
  localparam logic [2:0] SLOT_THIRD  = 3'd2;
  localparam logic [2:0] SLOT_FOURTH = 3'd3;
  localparam logic [2:0] SLOT_FEED   = 3'd4;

  // Byte counts of a group
  localparam logic [1:0] COUNT_ONE   = 2'd1;
  localparam logic [1:0] COUNT_TWO   = 2'd2;
  localparam logic [1:0] COUNT_THREE = 2'd3;

  // One classified group handed from front to back
  typedef struct packed {
    logic [23:0] bytes;   // first byte in 23:16, zero-filled when short
    logic [1:0]  count;   // bytes present, 1 to 3
    logic        feed;    // line feed follows the group
  } group_t;

  // Map a sextet onto the standard alphabet
  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < 6'd26) begin
      sextet_char = CHAR_UPPER_A + s8;
    end else if (s < 6'd52) begin
      sextet_char = CHAR_LOWER_OFS + s8;
    end else if (s < 6'd62) begin
      sextet_char = s8 - CHAR_DIGIT_OFS;
    end else if (s == 6'd62) begin
      sextet_char = CHAR_PLUS;
    end else begin
      sextet_char = CHAR_SLASH;
    end
  endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: accepts bytes, holds pending bytes, forms groups and decides line feeds.
// Depends on b64e_pkg for group_t, the byte counts and the config reset value.
`timescale 1ns / 1ps

module b64e_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                q_full,
  output logic                q_push,
  output b64e_pkg::group_t    q_data
);

  localparam logic [1:0] POS_NONE = 2'd0;
  localparam logic [1:0] POS_ONE  = 2'd1;
  localparam logic [1:0] POS_TWO  = 2'd2;

  logic [7:0] gpl_r;
  logic [1:0] pos_r, pos_nxt;
  logic [7:0] h0_r, h0_nxt;
  logic [7:0] h1_r, h1_nxt;
  logic [7:0] gcnt_r, gcnt_nxt;
  logic [7:0] gcnt_inc;
  logic       in_fire;
  logic       emit;
  logic       feed;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;
  assign gcnt_inc  = gcnt_r + 8'd1;

  // Classify the byte: hold it or close a group
  always_comb begin
    pos_nxt      = pos_r;
    h0_nxt       = h0_r;
    h1_nxt       = h1_r;
    gcnt_nxt     = gcnt_r;
    emit         = 1'b0;
    feed         = 1'b0;
    q_data.bytes = 24'd0;
    q_data.count = b64e_pkg::COUNT_THREE;
    case (pos_r)
      POS_NONE: begin
        if (in_tlast) begin
          emit         = 1'b1;
          q_data.bytes = {in_tdata, 16'd0};
          q_data.count = b64e_pkg::COUNT_ONE;
        end else begin
          h0_nxt  = in_tdata;
          pos_nxt = POS_ONE;
        end
      end
      POS_ONE: begin
        if (in_tlast) begin
          emit         = 1'b1;
          q_data.bytes = {h0_r, in_tdata, 8'd0};
          q_data.count = b64e_pkg::COUNT_TWO;
        end else begin
          h1_nxt  = in_tdata;
          pos_nxt = POS_TWO;
        end
      end
      default: begin
        emit         = 1'b1;
        q_data.bytes = {h0_r, h1_r, in_tdata};
        q_data.count = b64e_pkg::COUNT_THREE;
      end
    endcase
    if (emit) begin
      feed     = in_tlast || (gcnt_inc == gpl_r);
      gcnt_nxt = feed ? 8'd0 : gcnt_inc;
      pos_nxt  = POS_NONE;
    end
    q_data.feed = feed;
  end

  assign q_push = in_fire && emit;

  // Config register and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r  <= b64e_pkg::GROUPS_PER_LINE_RST;
      pos_r  <= POS_NONE;
      gcnt_r <= 8'd0;
    end else begin
      if (cfg_we) begin
        gpl_r <= cfg_wdata;
      end
      if (in_fire) begin
        pos_r  <= pos_nxt;
        gcnt_r <= gcnt_nxt;
      end
    end
  end

  // Pending bytes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      h0_r <= h0_nxt;
      h1_r <= h1_nxt;
    end
  end

endmodule

// ===== rtl/b64e_queue.sv =====
// Short register queue of groups between the front and back ends.
// Depends on b64e_pkg for group_t.
`timescale 1ns / 1ps

module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64e_pkg::group_t push_data,
  output logic             full,
  input  logic             pop,
  output b64e_pkg::group_t head,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_pkg::group_t slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Store the pushed group
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: serializes each group into characters, pads and line feed, one per cycle while out_tready is high.
// Depends on b64e_pkg for group_t, slot codes and the alphabet function.
`timescale 1ns / 1ps

module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  b64e_pkg::group_t q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  b64e_pkg::group_t cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       adv;
  logic       slot_last;
  logic [5:0] sextet;
  logic [7:0] char_sel;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // Output register is free when empty or being taken
  assign adv = cur_valid_r && (!out_valid_r || out_tready);

  // Pick the character of the current slot
  always_comb begin
    case (slot_r)
      b64e_pkg::SLOT_FIRST:  sextet = cur_r.bytes[23:18];
      b64e_pkg::SLOT_SECOND: sextet = cur_r.bytes[17:12];
      b64e_pkg::SLOT_THIRD:  sextet = cur_r.bytes[11:6];
      default:               sextet = cur_r.bytes[5:0];
    endcase
    char_sel  = b64e_pkg::sextet_char(sextet);
    slot_last = 1'b0;
    case (slot_r)
      b64e_pkg::SLOT_THIRD: begin
        if (cur_r.count == b64e_pkg::COUNT_ONE) begin
          char_sel = b64e_pkg::CHAR_PAD;
        end
      end
      b64e_pkg::SLOT_FOURTH: begin
        if (cur_r.count != b64e_pkg::COUNT_THREE) begin
          char_sel = b64e_pkg::CHAR_PAD;
        end
        slot_last = !cur_r.feed;
      end
      b64e_pkg::SLOT_FEED: begin
        char_sel  = b64e_pkg::CHAR_FEED;
        slot_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Take the next group when idle or finishing this one
  assign q_pop = !q_empty && (!cur_valid_r || (adv && slot_last));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    slot_nxt      = slot_r;
    if (adv) begin
      slot_nxt = slot_r + 3'd1;
      if (slot_last) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      slot_nxt      = b64e_pkg::SLOT_FIRST;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      slot_r      <= b64e_pkg::SLOT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      slot_r      <= slot_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (adv) begin
      out_char_r <= char_sel;
      out_last_r <= slot_last;
    end
  end

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Top level of the streaming base64 encoder: front end, group queue and back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
`timescale 1ns / 1ps

// Usage
//   Input stream in_*: one raw byte per item in in_tdata, in_tlast marks the
//   last byte of a stream. Output stream out_*: one ASCII character per item
//   (alphabet, '=' pad or line feed), out_tlast on the last character of
//   every group. cfg_we/cfg_wdata write groups_per_line; write it only
//   while the block is idle.
//   Every third byte, or a byte flagged last, closes a group of four
//   characters plus an optional line feed. The front end takes one byte per
//   cycle while the group queue has room; the back end sends one character
//   per cycle while out_tready is high, so the sustained input rate is set
//   by that serializer. The first character of a group passes through the
//   queue slot, the back end's group register and the output register.
//   A stall on out_tready holds the output register; the queue then fills
//   and in_tready drops once QUEUE_DEPTH groups are waiting.
//   Reset (rst_n low, synchronous) empties the queue, drops pending bytes,
//   clears the group count and sets groups_per_line to 16.

module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,    // groups_per_line
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // data_byte
  input  logic       in_tlast,     // end_of_stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // out_char
  output logic       out_tlast     // last_of_run
);

  b64e_pkg::group_t push_data;
  b64e_pkg::group_t head;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
